// File: rtl/utf8w_pkg.sv
// Shared types and constants for the UTF-8 to wide decoder.
// No dependencies.
package utf8w_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;

  localparam logic [2:0] LEAD2_TAG = 3'h6;
  localparam logic [3:0] LEAD3_TAG = 4'hE;
  localparam logic [4:0] LEAD4_TAG = 5'h1E;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_unit;
    logic        last_of_run;
    logic        from_final_byte;
  } out_item_t;

  // One finished code point between the front and back parts.
  typedef struct packed {
    logic [20:0] point;
    logic        fin;
    logic        utf16;
  } point_t;

endpackage

// File: rtl/utf8w_front.sv
// Front part: takes bytes, tracks the pending sequence and assembles code points.
// Depends on utf8w_pkg.
module utf8w_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  utf8w_pkg::in_item_t item,
  input  logic                utf16_mode,
  output logic                emit,
  output utf8w_pkg::point_t   emit_data
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [7:0]  c;

  assign c = item.in_byte;

  always_comb begin
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    emit      = 1'b0;
    emit_data = '{point: acc_r, fin: item.string_end, utf16: utf16_mode};
    if (accept) begin
      if (pend_r == 2'd0) begin
        if (c[7] == 1'b0) begin
          emit            = 1'b1;
          emit_data.point = {13'd0, c};
        end else if (c[7:5] == utf8w_pkg::LEAD2_TAG) begin
          acc_nxt  = {16'd0, c[4:0]};
          pend_nxt = 2'd1;
        end else if (c[7:4] == utf8w_pkg::LEAD3_TAG) begin
          acc_nxt  = {17'd0, c[3:0]};
          pend_nxt = 2'd2;
        end else if (c[7:3] == utf8w_pkg::LEAD4_TAG) begin
          acc_nxt  = {18'd0, c[2:0]};
          pend_nxt = 2'd3;
        end
        // string ends on a lead byte: emit the partial point
        if (c[7] == 1'b1 && pend_nxt != 2'd0 && item.string_end) begin
          emit            = 1'b1;
          emit_data.point = acc_nxt;
          pend_nxt        = 2'd0;
        end
      end else begin
        acc_nxt  = {acc_r[14:0], c[5:0]};
        pend_nxt = pend_r - 2'd1;
        if (pend_nxt == 2'd0 || item.string_end) begin
          emit            = 1'b1;
          emit_data.point = acc_nxt;
          pend_nxt        = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      acc_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// File: rtl/utf8w_queue.sv
// Short show-ahead queue of code points between front and back parts.
// Depends on utf8w_pkg.
module utf8w_queue #(
  parameter int unsigned Depth = utf8w_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  utf8w_pkg::point_t wr_data,
  input  logic              rd,
  output utf8w_pkg::point_t rd_data,
  output logic              q_full,
  output logic              q_empty
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  utf8w_pkg::point_t mem_r [Depth];
  logic [IdxW-1:0] wp_r, rp_r;
  logic [CntW-1:0] cnt_r;
  logic            do_wr, do_rd;

  assign q_full  = (cnt_r == FullCnt);
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == LastIdx) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == LastIdx) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/utf8w_back.sv
// Back part: encodes queued code points, splitting surrogate pairs, into the output register.
// Depends on utf8w_pkg.
module utf8w_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  utf8w_pkg::point_t    q_data,
  output logic                 q_rd,
  input  logic                 pop,
  output logic                 empty,
  output utf8w_pkg::out_item_t out_data
);

  logic                 phase_r, phase_nxt;
  logic                 valid_r, valid_nxt;
  utf8w_pkg::out_item_t data_r, data_nxt;
  logic                 load_ok, pair;
  logic [20:0]          v;
  logic [15:0]          hi_unit, lo_unit;

  assign v       = q_data.point - utf8w_pkg::SUPP_BASE;
  assign hi_unit = utf8w_pkg::HI_SURR + {5'd0, v[20:10]};
  assign lo_unit = utf8w_pkg::LO_SURR + {6'd0, v[9:0]};
  assign pair    = q_data.utf16 && (q_data.point[20:16] != 5'd0);
  assign load_ok = !valid_r || pop;

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r && !pop;
    data_nxt  = data_r;
    q_rd      = 1'b0;
    if (load_ok && !q_empty) begin
      valid_nxt                = 1'b1;
      data_nxt.from_final_byte = q_data.fin;
      if (pair && !phase_r) begin
        data_nxt.code_unit   = {5'd0, hi_unit};
        data_nxt.last_of_run = 1'b0;
        phase_nxt            = 1'b1;
      end else if (pair) begin
        data_nxt.code_unit   = {5'd0, lo_unit};
        data_nxt.last_of_run = 1'b1;
        phase_nxt            = 1'b0;
        q_rd                 = 1'b1;
      end else begin
        data_nxt.code_unit   = q_data.point;
        data_nxt.last_of_run = 1'b1;
        q_rd                 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign empty    = !valid_r;
  assign out_data = data_r;

endmodule

// File: rtl/utf8_to_wide_decoder.sv
// UTF-8 to wide-character decoder, top level.
// Depends on utf8w_pkg, utf8w_front, utf8w_queue, utf8w_back.
// Takes one UTF-8 byte per cycle while full is low and yields code points, or UTF-16 units
// with surrogate pairs when cfg_data=1 has been written. A byte is taken
// in the cycle it is pushed while full is low. Its first result passes
// through the queue and then the output register before it reaches the output ports.
// A code point above 0xFFFF in UTF-16 mode leaves as two units, one after the other,
// through the single output register; everything else sustains one transfer per cycle
// on both sides while full stays low and pop stays high. The queue between the byte front end
// and the output encoder holds QueueDepth code points; full is raised when
// it fills. Write the mode only while idle.
module utf8_to_wide_decoder #(
  parameter int unsigned QueueDepth = utf8w_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  utf8w_pkg::in_item_t  in_data,
  output logic                 empty,
  input  logic                 pop,
  output utf8w_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_data
);

  logic              utf16_mode_r;
  logic              q_full, q_empty, q_rd, emit;
  utf8w_pkg::point_t emit_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf16_mode_r <= 1'b0;
    end else if (cfg_we) begin
      utf16_mode_r <= cfg_data;
    end
  end

  assign full = q_full;

  utf8w_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (push && !q_full),
    .item       (in_data),
    .utf16_mode (utf16_mode_r),
    .emit       (emit),
    .emit_data  (emit_data)
  );

  utf8w_queue #(.Depth(QueueDepth)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (emit),
    .wr_data (emit_data),
    .rd      (q_rd),
    .rd_data (q_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  utf8w_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// File: tb/utf8_to_wide_decoder_test.sv
// Self-checking testbench for utf8_to_wide_decoder: a directed table, then random
// UTF-8 byte streams in both output modes, with random stalls on input and output.
// Depends on utf8w_pkg and the decoder RTL.
module utf8_to_wide_decoder_test;

  typedef enum logic [1:0] {ROW_PREDICTED, ROW_TYPED, ROW_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    utf8w_pkg::in_item_t  item;
    logic [1:0]           n_typed;
    utf8w_pkg::out_item_t typed_unit;
    logic                 mode_value;
  } directed_row_t;

  localparam int DirectedRows = 31;
  localparam int PhaseItems   = 425;
  localparam int SettleCycles = 4;

  logic                 clk;
  logic                 rst_n;
  logic                 push;
  logic                 full;
  utf8w_pkg::in_item_t  in_data;
  logic                 empty;
  logic                 pop;
  utf8w_pkg::out_item_t out_data;
  logic                 cfg_we;
  logic                 cfg_data;

  // decoder mirror
  logic                 utf16_mode_q;
  logic [1:0]           pending_count;
  logic [20:0]          acc_point;
  utf8w_pkg::out_item_t expected_units[$];

  int  mismatches;
  int  bytes_sent;
  int  units_checked;
  int  pairs_checked;
  int  hold_off_asked;

  directed_row_t directed_rows [DirectedRows];

  utf8_to_wide_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Advances the mirror by one accepted byte; queues its units when record is set.
  task automatic decode_byte(input utf8w_pkg::in_item_t item, input bit record);
    logic [7:0]  b;
    logic [20:0] point;
    logic [20:0] offset;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;
    bit          ready;
    bit          building;
    b        = item.in_byte;
    ready    = 1'b0;
    building = 1'b0;
    point    = '0;
    if (pending_count == 2'd0) begin
      if (!b[7]) begin
        point = {13'd0, b};
        ready = 1'b1;
      end else if (b[7:5] == utf8w_pkg::LEAD2_TAG) begin
        acc_point     = {16'd0, b[4:0]};
        pending_count = 2'd1;
        building      = 1'b1;
      end else if (b[7:4] == utf8w_pkg::LEAD3_TAG) begin
        acc_point     = {17'd0, b[3:0]};
        pending_count = 2'd2;
        building      = 1'b1;
      end else if (b[7:3] == utf8w_pkg::LEAD4_TAG) begin
        acc_point     = {18'd0, b[2:0]};
        pending_count = 2'd3;
        building      = 1'b1;
      end
    end else begin
      acc_point     = {acc_point[14:0], b[5:0]};
      pending_count = pending_count - 2'd1;
      building      = 1'b1;
    end
    if (building && (pending_count == 2'd0 || item.string_end)) begin
      pending_count = 2'd0;
      point         = acc_point;
      ready         = 1'b1;
    end
    if (ready && record) begin
      if (!utf16_mode_q || point <= 21'h00FFFF) begin
        expected_units.insert(expected_units.size(), '{point, 1'b1, item.string_end});
      end else begin
        offset  = point - utf8w_pkg::SUPP_BASE;
        hi_unit = utf8w_pkg::HI_SURR + 16'(offset >> 10);
        lo_unit = utf8w_pkg::LO_SURR + {6'd0, offset[9:0]};
        expected_units.insert(expected_units.size(),
                              '{{5'd0, hi_unit}, 1'b0, item.string_end});
        expected_units.insert(expected_units.size(),
                              '{{5'd0, lo_unit}, 1'b1, item.string_end});
      end
    end
  endtask

  task automatic send_byte(input utf8w_pkg::in_item_t item, input bit predicted);
    @(negedge clk);
    push    <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_byte(item, predicted);
    bytes_sent++;
  endtask

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  task automatic drain();
    pause(1);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_mode(input logic mode);
    drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    utf16_mode_q = mode;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int sender_gap(input bit gaps_on);
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic directed_row_t pred_row(input logic [7:0] b, input logic e);
    return '{ROW_PREDICTED, '{b, e}, 2'd0, '{21'd0, 1'b0, 1'b0}, 1'b0};
  endfunction

  function automatic directed_row_t typed_row(input logic [7:0] b, input logic e,
                                              input logic [1:0] n, input logic [20:0] unit);
    return '{ROW_TYPED, '{b, e}, n, '{unit, 1'b1, e}, 1'b0};
  endfunction

  function automatic directed_row_t mode_row(input logic m);
    return '{ROW_MODE, '{8'h00, 1'b0}, 2'd0, '{21'd0, 1'b0, 1'b0}, m};
  endfunction

  // result side: random pop with short and long stalls, and long unstalled runs
  initial begin : receiver
    int stall_left;
    int run_left;
    int r;
    int hold_off_seen;
    stall_left    = 0;
    run_left      = 0;
    hold_off_seen = 0;
    pop           = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_seen != hold_off_asked) begin
        hold_off_seen = hold_off_asked;
        stall_left    = 80;
        run_left      = 0;
      end
      if (stall_left == 0 && run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 60)      run_left   = $urandom_range(1, 8);
        else if (r < 68) run_left   = $urandom_range(30, 80);
        else if (r < 94) stall_left = $urandom_range(1, 3);
        else             stall_left = $urandom_range(10, 30);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        run_left--;
      end
    end
  end

  always @(posedge clk) begin
    utf8w_pkg::out_item_t want;
    if (rst_n && pop && !empty) begin
      if (expected_units.size() == 0) begin
        $error("unexpected transfer: code_unit %h last_of_run %b from_final_byte %b",
               out_data.code_unit, out_data.last_of_run, out_data.from_final_byte);
        mismatches++;
      end else begin
        want = expected_units.pop_front();
        units_checked++;
        if (!want.last_of_run) pairs_checked++;
        if (out_data.code_unit !== want.code_unit) begin
          $error("code_unit: expected %h, got %h", want.code_unit, out_data.code_unit);
          mismatches++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, out_data.last_of_run);
          mismatches++;
        end
        if (out_data.from_final_byte !== want.from_final_byte) begin
          $error("from_final_byte: expected %b, got %b",
                 want.from_final_byte, out_data.from_final_byte);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    utf8w_pkg::in_item_t item;
    logic [7:0]          b;
    bit                  ignored;
    bit                  gaps_on;
    bit                  drained;
    int                  cont_left;
    int                  counted;
    int                  burst;
    int                  r;
    int                  len;
    int                  g;

    rst_n          = 1'b0;
    push           = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_data       = 1'b0;
    hold_off_asked = 0;
    utf16_mode_q   = 1'b0;
    pending_count  = 2'd0;
    acc_point      = '0;
    mismatches     = 0;
    bytes_sent     = 0;
    units_checked  = 0;
    pairs_checked  = 0;
    cont_left      = 0;
    drained        = 1'b0;
    gaps_on        = 1'b1;

    directed_rows = '{
      typed_row(8'h00, 1'b0, 2'd1, 21'h000000),
      typed_row(8'h7F, 1'b1, 2'd1, 21'h00007F),
      typed_row(8'h80, 1'b0, 2'd0, 21'h000000),   // stray continuation: skipped
      typed_row(8'hFF, 1'b1, 2'd0, 21'h000000),
      typed_row(8'hF8, 1'b0, 2'd0, 21'h000000),
      pred_row(8'hC2, 1'b0), pred_row(8'hA9, 1'b0),
      pred_row(8'hE2, 1'b0), pred_row(8'h82, 1'b0), pred_row(8'hAC, 1'b0),
      pred_row(8'hF4, 1'b0), pred_row(8'h8F, 1'b0), pred_row(8'hBF, 1'b0),
      pred_row(8'hBF, 1'b0),
      pred_row(8'hE0, 1'b0), pred_row(8'hC0, 1'b1), // lead-like byte, string cut short
      mode_row(1'b1),
      pred_row(8'hF0, 1'b0), pred_row(8'h9F, 1'b0), pred_row(8'h98, 1'b0),
      pred_row(8'h80, 1'b0),
      pred_row(8'hF7, 1'b0), pred_row(8'hBF, 1'b0), pred_row(8'hBF, 1'b0),
      pred_row(8'hBF, 1'b1),                        // widest point, pair wraps
      typed_row(8'h41, 1'b1, 2'd1, 21'h000041),
      pred_row(8'hF0, 1'b0), pred_row(8'h90, 1'b0),
      mode_row(1'b0),                               // mode flips mid-sequence
      pred_row(8'h80, 1'b0), pred_row(8'h80, 1'b0)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_MODE: begin
          set_mode(directed_rows[i].mode_value);
        end
        ROW_TYPED: begin
          if (directed_rows[i].n_typed != 2'd0)
            expected_units.insert(expected_units.size(), directed_rows[i].typed_unit);
          g = sender_gap(1'b1);
          pause(g);
          send_byte(directed_rows[i].item, 1'b0);
        end
        default: begin
          g = sender_gap(1'b1);
          pause(g);
          send_byte(directed_rows[i].item, 1'b1);
        end
      endcase
    end

    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase % 2 == 0);
      burst   = 0;
      counted = 0;
      if (phase == 0) begin
        // receiver holds off while bytes keep coming, so the queue fills
        @(posedge clk);
        hold_off_asked++;
        burst = 48;
      end
      while (counted < PhaseItems) begin
        if (counted % 100 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        if (phase == 2 && counted == PhaseItems / 2 && !drained) begin
          drain();
          drained = 1'b1;
        end
        if (cont_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 12) begin
            b = 8'($urandom_range(0, 255));
          end else begin
            len = $urandom_range(1, 4);
            case (len)
              1:       b = {1'b0, 7'($urandom)};
              2:       b = {utf8w_pkg::LEAD2_TAG, 5'($urandom)};
              3:       b = {utf8w_pkg::LEAD3_TAG, 4'($urandom)};
              default: b = {utf8w_pkg::LEAD4_TAG, 3'($urandom)};
            endcase
            cont_left = len - 1;
          end
        end else begin
          if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
          else                           b = {2'b10, 6'($urandom)};
          cont_left--;
        end
        item.in_byte    = b;
        item.string_end = ($urandom_range(0, 9) == 0);
        if (item.string_end) cont_left = 0;
        ignored = (pending_count == 2'd0) && (b[7:6] == 2'b10 || b[7:3] == 5'b11111);
        if (burst > 0) begin
          burst--;
        end else begin
          g = sender_gap(gaps_on);
          pause(g);
        end
        send_byte(item, 1'b1);
        if (!ignored) counted++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Run: %0d bytes (directed table then four random phases, both modes),",
             bytes_sent);
    $display("  %0d units checked, %0d of them surrogate pairs, %0d mismatches.",
             units_checked, pairs_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
